/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the orbit occupation accumulator.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An overlapping implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/ooa_pkg.sv */
// Package of the orbit occupation accumulator: sizes, stream packing offsets,
// request codes and data types. Depends on nothing.
package ooa_pkg;

  // Design size.
  localparam int NUM_STATE_BITS = 64;
  localparam int NUM_BINS       = 16;

  // Field widths.
  localparam int REQ_W     = 2;
  localparam int AMP_W     = 16;
  localparam int PAT_W     = 64;
  localparam int IDX_W     = 6;
  localparam int MAPV_W    = 4;
  localparam int PC_W      = 7;
  localparam int BIN_W     = 40;
  localparam int BIN_NUM_W = 4;
  localparam int RUN_W     = 32;

  // Digit-serial squarer: magnitude of a Q1.15 value is held in 17 bits.
  localparam int MAG_W      = AMP_W + 1;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = (MAG_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MPLR_W     = NUM_DIGITS * DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  // Address widths of the map and of the bin file.
  localparam int MAP_AW = $clog2(NUM_STATE_BITS);
  localparam int BIN_AW = $clog2(NUM_BINS);
  localparam int EXT_W  = IDX_W + 1;

  // Input tdata packing, lowest bits first.
  localparam int AMP_LSB      = 0;
  localparam int PAT_LSB      = AMP_LSB + AMP_W;
  localparam int IDX_LSB      = PAT_LSB + PAT_W;
  localparam int MAPV_LSB     = IDX_LSB + IDX_W;
  localparam int IN_FIELDS_W  = MAPV_LSB + MAPV_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata packing, lowest bits first.
  localparam int BIN_VAL_LSB  = 0;
  localparam int BIN_NUM_LSB  = BIN_VAL_LSB + BIN_W;
  localparam int OUT_FIELDS_W = BIN_NUM_LSB + BIN_NUM_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Request codes carried on in_tuser.
  localparam logic [REQ_W-1:0] REQ_MAP_WR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACCUM  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  typedef logic [BIN_W-1:0] bin_t;
  typedef logic [RUN_W-1:0] run_t;

endpackage

/* design/ooa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the orbit-to-bin map.
module ooa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/orbit_occupation_accumulator.sv */
// Orbit occupation accumulator: one request per transfer on the in_ stream, kind on in_tuser.
// A map write or a bin clear completes in the transfer cycle. An amplitude takes the transfer,
// a multiply state in which a 17x4 multiplier squares the magnitude one 4-bit digit at a time,
// and a state for the saturating run-sum add. An amplitude with in_tlast adds a walk over the
// occupancy pattern at one bit per cycle, ending after the highest set bit that is used or when
// particle_count bits are taken, then a drain state for the last bin update; the walk length is
// set by the pattern and particle_count, and the map RAM gives one entry per cycle. A bin read
// yields one transfer on the out_ stream once the output register is free; the next request may
// be taken while that result still waits. Bins are flip-flops cleared by reset, so no clearing
// pass is needed. Depends on ooa_pkg, ooa_ram and assert_macros.svh.
`include "assert_macros.svh"

module orbit_occupation_accumulator (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration: particle_count.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ooa_pkg::PC_W-1:0]         cfg_data,
  // Requests.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // amplitude [15:0], occupancy_pattern [79:16], entry_index [85:80],
  // map_value [89:86], zero padding above.
  input  logic [ooa_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,   // last_in_run
  input  logic [ooa_pkg::REQ_W-1:0]        in_tuser,   // req_type
  // Bin read results.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // bin_value [39:0], bin_number [43:40], zero padding above.
  output logic [ooa_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser   // overflow_seen
);

  import ooa_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_RDOUT = 3'd5;

  localparam logic [EXT_W-1:0] STATE_BITS_LIM = EXT_W'(NUM_STATE_BITS);
  localparam logic [EXT_W-1:0] BINS_LIM       = EXT_W'(NUM_BINS);

  // Unpacked request fields.
  logic [AMP_W-1:0]  in_amp;
  logic [PAT_W-1:0]  in_pat;
  logic [IDX_W-1:0]  in_idx;
  logic [MAPV_W-1:0] in_mapv;
  logic              in_xfer;

  assign in_amp  = in_tdata[AMP_LSB  +: AMP_W];
  assign in_pat  = in_tdata[PAT_LSB  +: PAT_W];
  assign in_idx  = in_tdata[IDX_LSB  +: IDX_W];
  assign in_mapv = in_tdata[MAPV_LSB +: MAPV_W];

  // Control state.
  logic [2:0]          state_r, state_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  run_t                run_sum_r, run_sum_nxt;
  logic                sat_flag_r, sat_flag_nxt;
  bin_t                bins_r [NUM_BINS];
  bin_t                bins_nxt [NUM_BINS];
  logic                add_v_r, add_v_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic [MPLR_W-1:0]    mplr_r, mplr_nxt;
  run_t                 acc_r, acc_nxt;
  logic [DIG_CNT_W-1:0] dig_r, dig_nxt;
  logic                 last_r, last_nxt;
  logic [NUM_STATE_BITS-1:0] pat_r, pat_nxt;
  logic [MAP_AW-1:0]    bit_r, bit_nxt;
  logic [PC_W-1:0]      taken_r, taken_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  bin_t                 out_val_r, out_val_nxt;
  logic [BIN_NUM_W-1:0] out_num_r, out_num_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  // Map RAM connections.
  logic              map_we;
  logic [MAP_AW-1:0] map_raddr;
  logic [MAPV_W-1:0] map_rdata;

  ooa_ram #(
    .WIDTH (MAPV_W),
    .DEPTH (NUM_STATE_BITS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (in_idx[MAP_AW-1:0]),
    .wdata (in_mapv),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // The block takes one request at a time; configuration only between requests.
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  assign map_we    = in_xfer && (in_tuser == REQ_MAP_WR) &&
                     ({1'b0, in_idx} < STATE_BITS_LIM);
  assign map_raddr = bit_r;

  // Magnitude of the two's complement amplitude; the most negative value gives 2^15.
  logic [MAG_W-1:0] in_mag;
  assign in_mag = in_amp[AMP_W-1] ? (MAG_W'(0) - {in_amp[AMP_W-1], in_amp})
                                  : {1'b0, in_amp};

  // One digit of the multiplier per cycle, most significant digit first.
  logic [MAG_W+DIGIT_W-1:0] partial;
  assign partial = mag_r * mplr_r[MPLR_W-1 -: DIGIT_W];

  // Saturating run-sum update.
  logic [RUN_W:0] run_total;
  assign run_total = {1'b0, run_sum_r} + {1'b0, acc_r};

  // Bin update, in the cycle after the map entry of a taken bit was read.
  logic [EXT_W-1:0] upd_bin_ext;
  logic             upd_ok;
  logic [BIN_AW-1:0] upd_bin;
  logic [BIN_W:0]   bin_total;

  assign upd_bin_ext = EXT_W'(map_rdata);
  assign upd_ok      = add_v_r && (upd_bin_ext < BINS_LIM);
  assign upd_bin     = upd_bin_ext[BIN_AW-1:0];
  assign bin_total   = {1'b0, bins_r[upd_bin]} + {{(BIN_W-RUN_W+1){1'b0}}, run_sum_r};

  // Bin read.
  logic [EXT_W-1:0] rd_ext;
  logic             rd_ok;
  logic             out_free;

  assign rd_ext   = {1'b0, rd_idx_r};
  assign rd_ok    = rd_ext < BINS_LIM;
  assign out_free = !out_valid_r || out_tready;

  // Walk step: take the lowest remaining pattern bit while the count allows.
  logic take;
  assign take = pat_r[0] && (taken_r < pc_r);

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    run_sum_nxt   = run_sum_r;
    sat_flag_nxt  = sat_flag_r;
    bins_nxt      = bins_r;
    add_v_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    mag_nxt       = mag_r;
    mplr_nxt      = mplr_r;
    acc_nxt       = acc_r;
    dig_nxt       = dig_r;
    last_nxt      = last_r;
    pat_nxt       = pat_r;
    bit_nxt       = bit_r;
    taken_nxt     = taken_r;
    rd_idx_nxt    = rd_idx_r;
    out_val_nxt   = out_val_r;
    out_num_nxt   = out_num_r;
    out_ovf_nxt   = out_ovf_r;

    if (cfg_valid && cfg_ready) begin
      pc_nxt = cfg_data;
    end

    // Pending bin addition from the walk.
    if (upd_ok) begin
      if (bin_total[BIN_W]) begin
        bins_nxt[upd_bin] = {BIN_W{1'b1}};
        sat_flag_nxt      = 1'b1;
      end else begin
        bins_nxt[upd_bin] = bin_total[BIN_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            REQ_ACCUM: begin
              mag_nxt   = in_mag;
              mplr_nxt  = MPLR_W'(in_mag);
              acc_nxt   = '0;
              dig_nxt   = '0;
              last_nxt  = in_tlast;
              pat_nxt   = in_pat[NUM_STATE_BITS-1:0];
              state_nxt = ST_MUL;
            end
            REQ_CLEAR: begin
              for (int i = 0; i < NUM_BINS; i++) begin
                bins_nxt[i] = '0;
              end
              sat_flag_nxt = 1'b0;
            end
            REQ_READ: begin
              rd_idx_nxt = in_idx;
              state_nxt  = ST_RDOUT;
            end
            default: begin
              // Map writes go straight to the RAM.
            end
          endcase
        end
      end

      ST_MUL: begin
        acc_nxt  = {acc_r[RUN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + RUN_W'(partial);
        mplr_nxt = {mplr_r[MPLR_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        dig_nxt  = dig_r + 1'b1;
        if (dig_r == DIG_CNT_W'(NUM_DIGITS - 1)) begin
          state_nxt = ST_SUM;
        end
      end

      ST_SUM: begin
        if (run_total[RUN_W]) begin
          run_sum_nxt  = {RUN_W{1'b1}};
          sat_flag_nxt = 1'b1;
        end else begin
          run_sum_nxt = run_total[RUN_W-1:0];
        end
        bit_nxt   = '0;
        taken_nxt = '0;
        state_nxt = last_r ? ST_WALK : ST_IDLE;
      end

      ST_WALK: begin
        add_v_nxt = take;
        if (take) begin
          taken_nxt = taken_r + 1'b1;
        end
        pat_nxt = pat_r >> 1;
        bit_nxt = bit_r + 1'b1;
        // Stop once no set bit is left or the particle count is reached.
        if ((pat_nxt == '0) || (taken_nxt >= pc_r)) begin
          state_nxt = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        // The last bin update uses the run sum in this cycle; the run then restarts.
        run_sum_nxt = '0;
        state_nxt   = ST_IDLE;
      end

      ST_RDOUT: begin
        if (out_free) begin
          out_val_nxt   = rd_ok ? bins_r[rd_ext[BIN_AW-1:0]] : '0;
          out_num_nxt   = rd_idx_r[BIN_NUM_W-1:0];
          out_ovf_nxt   = sat_flag_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= PC_W'(1);
      run_sum_r   <= '0;
      sat_flag_r  <= 1'b0;
      add_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      run_sum_r   <= run_sum_nxt;
      sat_flag_r  <= sat_flag_nxt;
      add_v_r     <= add_v_nxt;
      out_valid_r <= out_valid_nxt;
      bins_r      <= bins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    mplr_r    <= mplr_nxt;
    acc_r     <= acc_nxt;
    dig_r     <= dig_nxt;
    last_r    <= last_nxt;
    pat_r     <= pat_nxt;
    bit_r     <= bit_nxt;
    taken_r   <= taken_nxt;
    rd_idx_r  <= rd_idx_nxt;
    out_val_r <= out_val_nxt;
    out_num_r <= out_num_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_num_r, out_val_r};
  assign out_tuser  = out_ovf_r;

  // A bin update only follows a walk step that read the map.
  `ASSERT_IMPLIES(a_add_after_walk, add_v_r, $past(state_r) == ST_WALK, "bin update without walk step")
  // The walk never takes more orbit bits than the particle count.
  `ASSERT_ALWAYS(a_taken_bound, (state_r != ST_WALK) || (taken_r <= pc_r), "walk took too many bits")
  // After a run has been distributed the run sum starts from zero.
  `ASSERT_IMPLIES(a_run_restart, $past(state_r) == ST_DRAIN, run_sum_r == '0, "run sum kept after run end")
  // A new result only appears when a read has been processed.
  `ASSERT_IMPLIES(a_result_source, $rose(out_valid_r), $past(state_r) == ST_RDOUT, "result without read")

endmodule
